/* hw/rtl/bblur_pkg.sv */
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and arithmetic helpers for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 4096;

  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KindPixel = 1'b0,
    KindDrain = 1'b1
  } kind_e;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned SumW       = 12;
  localparam int unsigned RecipW     = 14;
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam int unsigned RecipShift = 16;
  // ceil(2^16 / n); exact for sums below 2^15
  localparam logic [RecipW-1:0] Recip6 = 14'd10923;
  localparam logic [RecipW-1:0] Recip9 = 14'd7282;

  typedef enum logic [1:0] {
    Div4,
    Div6,
    Div9
  } div_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  // index 0 = top row, 1 = middle row, 2 = bottom row
  typedef pix_t [2:0] col_t;

  // line buffer entry: two rows of one column
  typedef struct packed {
    pix_t older;
    pix_t prior;
  } entry_t;

  typedef logic [SumW-1:0] sum_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } sum_rgb_t;

  function automatic sum_rgb_t col_sum(col_t col, logic use_top);
    pix_t     top;
    sum_rgb_t s;
    top     = use_top ? col[0] : '0;
    s.red   = SumW'(top.red) + SumW'(col[1].red) + SumW'(col[2].red);
    s.green = SumW'(top.green) + SumW'(col[1].green) + SumW'(col[2].green);
    s.blue  = SumW'(top.blue) + SumW'(col[1].blue) + SumW'(col[2].blue);
    return s;
  endfunction

  function automatic sum_rgb_t sum_add(sum_rgb_t a, sum_rgb_t b);
    sum_rgb_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    return s;
  endfunction

  // (sum + n/2) / n, rounded half up
  function automatic logic [ChanW-1:0] div_round(sum_t sum, div_e div);
    sum_t             biased;
    logic [ProdW-1:0] prod;
    logic [ChanW-1:0] q;
    case (div)
      Div4: begin
        biased = sum + SumW'(2);
        prod   = '0;
        q      = biased[ChanW+1:2];
      end
      Div6: begin
        biased = sum + SumW'(3);
        prod   = ProdW'(biased) * ProdW'(Recip6);
        q      = prod[RecipShift +: ChanW];
      end
      Div9: begin
        biased = sum + SumW'(4);
        prod   = ProdW'(biased) * ProdW'(Recip9);
        q      = prod[RecipShift +: ChanW];
      end
      default: begin
        biased = sum;
        prod   = '0;
        q      = '0;
      end
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over RGB pixels in raster order.
//
// Input channel (in_valid_i/in_ready_o): one request per pixel (kind 0) or
// drain tick (kind 1). Output channel (out_valid_o/out_ready_i): blurred
// pixels, last_of_run_o on the final result of a request, frame_end_o on the
// last pixel of the image. Output (r,c) leaves with input (r+1,c+1); the
// right column follows right after; the bottom row leaves one per drain tick.
// Throughput: one request per clock while the receiver keeps up. A right-edge
// pixel gives two results and holds the output stage until both have left.
// The line buffer is one 48-bit wide memory read and written once per clock.
// The first result passes the memory read, the adder stage and the divide
// into the output register.
// A stalled receiver holds the output register; the pipeline behind it fills
// and in_ready_o drops. Reset clears counters and pipeline valids; the line
// buffer is not cleared. A configuration write restarts the frame and must
// be issued only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH  = bblur_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bblur_pkg::MaxHeightDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bblur_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bblur_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             kind_i,
  input  wire logic [bblur_pkg::ChanW-1:0]      pixel_red_i,
  input  wire logic [bblur_pkg::ChanW-1:0]      pixel_green_i,
  input  wire logic [bblur_pkg::ChanW-1:0]      pixel_blue_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [bblur_pkg::ChanW-1:0]           blur_red_o,
  output logic [bblur_pkg::ChanW-1:0]           blur_green_o,
  output logic [bblur_pkg::ChanW-1:0]           blur_blue_o,
  output logic                                  last_of_run_o,
  output logic                                  frame_end_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic drain;
    logic emit;
    logic use_top;
    logic use_a;
    logic use_c;
    logic right;
    logic fend;
    logic first;
    logic col0;
  } s1_ctrl_t;

  // configuration
  logic [bblur_pkg::FrameWidthW-1:0]  frame_width_q;
  logic [bblur_pkg::FrameHeightW-1:0] frame_height_q;
  logic [WW-1:0]                      eff_w;
  logic [HW-1:0]                      eff_h;

  // frame position
  logic [CW-1:0] col_q, drain_q;
  logic [RW-1:0] row_q;
  logic          draining_q;
  logic [WW-1:0] col_ext, col_inc, drn_ext, drn_inc;
  logic [HW-1:0] row_ext, row_inc;

  logic          in_take, pix_go, drn_go, s1_load;
  s1_ctrl_t      ctrl_d;
  logic [CW-1:0] addr_d;

  // stage 1: memory read
  logic               s1_valid_q;
  s1_ctrl_t           s1_ctrl_q;
  logic [CW-1:0]      s1_addr_q;
  bblur_pkg::pix_t    s1_pix_q;
  logic               s1_go;

  bblur_pkg::entry_t  line_mem [MAX_WIDTH];
  logic [CW-1:0]      rd_addr;
  bblur_pkg::entry_t  rd_data_q, fwd_data_q, cur_entry, mem_wdata;
  logic               fwd_hit_q, mem_we;

  bblur_pkg::col_t    win0_q, win1_q, col_a, col_b, col_c;
  bblur_pkg::entry_t  first_col_q;
  bblur_pkg::sum_rgb_t sum_a, sum_b, sum_c, sum_main, sum_sec;
  bblur_pkg::div_e    div_main, div_sec;

  // stage 2: sums
  logic                s2_valid_q, s2_phase_q, s2_has_sec_q, s2_fend_q;
  bblur_pkg::sum_rgb_t s2_main_q, s2_sec_q;
  bblur_pkg::div_e     s2_div_main_q, s2_div_sec_q;
  logic                s2_free, sel_last, out_free, out_take;
  bblur_pkg::sum_rgb_t sel_sum;
  bblur_pkg::div_e     sel_div;

  // output register
  logic                        out_valid_q, out_last_q, out_fend_q;
  logic [bblur_pkg::ChanW-1:0] out_red_q, out_green_q, out_blue_q;

  always_comb begin
    if (frame_width_q < bblur_pkg::FrameWidthW'(2)) begin
      eff_w = WW'(2);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_q);
    end
    if (frame_height_q < bblur_pkg::FrameHeightW'(2)) begin
      eff_h = HW'(2);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height_q);
    end
  end

  assign col_ext = WW'(col_q);
  assign col_inc = col_ext + WW'(1);
  assign drn_ext = WW'(drain_q);
  assign drn_inc = drn_ext + WW'(1);
  assign row_ext = HW'(row_q);
  assign row_inc = row_ext + HW'(1);

  assign in_take = in_valid_i && in_ready_o;
  assign pix_go  = in_take && (kind_i == bblur_pkg::KindPixel) && !draining_q
                   && (col_ext < eff_w);
  assign drn_go  = in_take && (kind_i == bblur_pkg::KindDrain) && draining_q
                   && (drn_ext < eff_w);
  assign s1_load = pix_go || drn_go;

  always_comb begin
    ctrl_d = '0;
    addr_d = col_q;
    if (kind_i == bblur_pkg::KindDrain) begin
      ctrl_d.drain = 1'b1;
      ctrl_d.emit  = 1'b1;
      ctrl_d.use_a = (drain_q != '0);
      ctrl_d.use_c = (drn_inc < eff_w);
      ctrl_d.fend  = (drn_inc == eff_w);
      ctrl_d.first = (drain_q == '0);
      addr_d       = ctrl_d.use_c ? CW'(drn_inc) : '0;
    end else begin
      ctrl_d.emit    = (row_q != '0) && (col_q != '0);
      ctrl_d.use_top = (row_ext >= HW'(2));
      ctrl_d.use_a   = (col_ext >= WW'(2));
      ctrl_d.use_c   = 1'b1;
      ctrl_d.right   = (col_inc == eff_w);
      ctrl_d.col0    = (col_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bblur_pkg::FrameWidthReset;
      frame_height_q <= bblur_pkg::FrameHeightReset;
      col_q          <= '0;
      row_q          <= '0;
      drain_q        <= '0;
      draining_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bblur_pkg::RegFrameWidth: begin
          frame_width_q <= cfg_wdata_i[bblur_pkg::FrameWidthW-1:0];
        end
        bblur_pkg::RegFrameHeight: begin
          frame_height_q <= cfg_wdata_i[bblur_pkg::FrameHeightW-1:0];
        end
        default: begin
        end
      endcase
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
    end else if (pix_go) begin
      if (col_inc >= eff_w) begin
        col_q <= '0;
        if (row_inc >= eff_h) begin
          row_q      <= '0;
          drain_q    <= '0;
          draining_q <= 1'b1;
        end else begin
          row_q <= RW'(row_inc);
        end
      end else begin
        col_q <= CW'(col_inc);
      end
    end else if (drn_go) begin
      if (drn_inc >= eff_w) begin
        drain_q    <= '0;
        draining_q <= 1'b0;
        col_q      <= '0;
        row_q      <= '0;
      end else begin
        drain_q <= CW'(drn_inc);
      end
    end
  end

  // stage 1
  assign s1_go      = s1_valid_q && (!s1_ctrl_q.emit || s2_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ctrl_q <= ctrl_d;
      s1_addr_q <= addr_d;
      s1_pix_q  <= '{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i};
    end
  end

  // a held request re-reads its own address every cycle
  assign rd_addr   = s1_load ? addr_d : s1_addr_q;
  assign mem_we    = s1_go && !s1_ctrl_q.drain;
  assign cur_entry = fwd_hit_q ? fwd_data_q : rd_data_q;
  assign mem_wdata = '{older: cur_entry.prior, prior: s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_addr_q] <= mem_wdata;
    end
    rd_data_q <= line_mem[rd_addr];
  end

  // read and write to one entry in the same cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= mem_we && (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= mem_wdata;
  end

  always_comb begin
    col_a = win1_q;
    col_b = win0_q;
    col_c = '0;
    if (s1_ctrl_q.drain) begin
      if (s1_ctrl_q.first) begin
        col_b[0] = '0;
        col_b[1] = first_col_q.older;
        col_b[2] = first_col_q.prior;
      end
      col_c[1] = cur_entry.older;
      col_c[2] = cur_entry.prior;
    end else begin
      col_c[0] = cur_entry.older;
      col_c[1] = cur_entry.prior;
      col_c[2] = s1_pix_q;
    end
  end

  always_comb begin
    sum_a    = s1_ctrl_q.use_a ? bblur_pkg::col_sum(col_a, s1_ctrl_q.use_top) : '0;
    sum_b    = bblur_pkg::col_sum(col_b, s1_ctrl_q.use_top);
    sum_c    = s1_ctrl_q.use_c ? bblur_pkg::col_sum(col_c, s1_ctrl_q.use_top) : '0;
    sum_sec  = bblur_pkg::sum_add(sum_b, sum_c);
    sum_main = bblur_pkg::sum_add(sum_sec, sum_a);
    if (s1_ctrl_q.use_top && s1_ctrl_q.use_a && s1_ctrl_q.use_c) begin
      div_main = bblur_pkg::Div9;
    end else if (s1_ctrl_q.use_top || (s1_ctrl_q.use_a && s1_ctrl_q.use_c)) begin
      div_main = bblur_pkg::Div6;
    end else begin
      div_main = bblur_pkg::Div4;
    end
    div_sec = s1_ctrl_q.use_top ? bblur_pkg::Div6 : bblur_pkg::Div4;
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      win1_q <= col_b;
      win0_q <= col_c;
      if (!s1_ctrl_q.drain && s1_ctrl_q.col0) begin
        first_col_q <= mem_wdata;
      end
    end
  end

  // stage 2
  assign sel_last = s2_phase_q || !s2_has_sec_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_take = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || (out_take && sel_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      s2_phase_q   <= 1'b0;
      s2_has_sec_q <= 1'b0;
    end else if (s1_go && s1_ctrl_q.emit) begin
      s2_valid_q   <= 1'b1;
      s2_phase_q   <= 1'b0;
      s2_has_sec_q <= s1_ctrl_q.right;
    end else if (out_take && sel_last) begin
      s2_valid_q <= 1'b0;
    end else if (out_take) begin
      s2_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_ctrl_q.emit) begin
      s2_main_q     <= sum_main;
      s2_sec_q      <= sum_sec;
      s2_div_main_q <= div_main;
      s2_div_sec_q  <= div_sec;
      s2_fend_q     <= s1_ctrl_q.fend;
    end
  end

  assign sel_sum = s2_phase_q ? s2_sec_q : s2_main_q;
  assign sel_div = s2_phase_q ? s2_div_sec_q : s2_div_main_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_red_q   <= bblur_pkg::div_round(sel_sum.red, sel_div);
      out_green_q <= bblur_pkg::div_round(sel_sum.green, sel_div);
      out_blue_q  <= bblur_pkg::div_round(sel_sum.blue, sel_div);
      out_last_q  <= sel_last;
      out_fend_q  <= s2_fend_q && !s2_phase_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign blur_red_o    = out_red_q;
  assign blur_green_o  = out_green_q;
  assign blur_blue_o   = out_blue_q;
  assign last_of_run_o = out_last_q;
  assign frame_end_o   = out_fend_q;

`ifndef SYNTHESIS
  a_phase_needs_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_phase_q) |-> s2_has_sec_q)
    else $error("second result phase without a second result");

  a_position_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_ext < eff_w) && (row_ext < eff_h))
    else $error("frame position outside the frame");

  a_drain_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> ((col_q == '0) && (row_q == '0)))
    else $error("draining with nonzero pixel position");

  a_frame_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> last_of_run_o)
    else $error("frame end on a result that is not last of its request");
`endif

endmodule

`default_nettype wire
